// ===== hw/rtl/pvf_pkg.sv =====
// ----------------------------------------------------------------------------
// pvf_pkg
// Shared widths, register indexes and result codes of the profile valley finder.
// ----------------------------------------------------------------------------
package pvf_pkg;

    localparam int unsigned POS_BITS    = 10;
    localparam int unsigned SAMPLE_BITS = 16;
    localparam int unsigned CEIL_BITS   = 16;
    localparam int unsigned CFG_IDX_BITS  = 2;
    localparam int unsigned CFG_DATA_BITS = 16;

    localparam logic [CEIL_BITS-1:0] CEIL_RESET = CEIL_BITS'(10000);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_START_INDEX    = 2'd0,
        CFG_SCAN_DIRECTION = 2'd1,
        CFG_VALUE_CEILING  = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        OUTCOME_VALLEY = 2'd0,
        OUTCOME_CHANGE = 2'd1,
        OUTCOME_NONE   = 2'd2
    } t_outcome;

endpackage

// ===== hw/rtl/profile_valley_finder.sv =====
// ----------------------------------------------------------------------------
// profile_valley_finder
// Scans profile samples and reports the deepest flat-bottomed valley below a
// ceiling, or the latest change point when no valley qualifies.
// ----------------------------------------------------------------------------
// result: registered on the output in the cycle after its last sample is
//   accepted
// throughput: one sample per cycle; scan state is updated in the accept cycle
//   and the result register frees the input side unless a result is stalled
// reset: synchronous active low; clears scan state and the output valid, and
//   loads the registers with start 0, ascending, ceiling 10000
module profile_valley_finder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pvf_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [pvf_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [pvf_pkg::SAMPLE_BITS-1:0]     i_sample_value,
    input  logic                                i_is_last,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [pvf_pkg::POS_BITS-1:0]        o_valley_position,
    output logic [1:0]                          o_outcome
);
    import pvf_pkg::*;

    // configuration
    logic [POS_BITS-1:0]    r_start_index;
    logic                   r_scan_dir;
    logic [CEIL_BITS-1:0]   r_ceiling;

    // scan state
    logic [SAMPLE_BITS-1:0] r_prev,      n_prev;
    logic                   r_have_prev, n_have_prev;
    logic [POS_BITS-1:0]    r_chg_pos,   n_chg_pos;
    logic                   r_chg_seen,  n_chg_seen;
    logic [SAMPLE_BITS-1:0] r_best_val,  n_best_val;
    logic [POS_BITS-1:0]    r_best_pos,  n_best_pos;
    logic                   r_best_valid, n_best_valid;
    logic [POS_BITS-1:0]    r_cur_pos,   n_cur_pos;

    // result register
    logic                   r_out_valid;
    logic [POS_BITS-1:0]    r_out_pos,   n_out_pos;
    t_outcome               r_outcome,   n_outcome;

    logic                   in_accept;
    logic [POS_BITS-1:0]    pos;
    logic [SAMPLE_BITS-1:0] prev_eff;
    logic [POS_BITS-1:0]    chg_pos_eff;
    logic                   fall;
    logic                   rise;
    logic                   take;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    always_comb begin
        // first sample of a scan sits at the start index and is its own reference
        if (r_have_prev) begin
            pos = r_scan_dir ? (r_cur_pos - POS_BITS'(1)) : (r_cur_pos + POS_BITS'(1));
            prev_eff    = r_prev;
            chg_pos_eff = r_chg_pos;
        end else begin
            pos         = r_start_index;
            prev_eff    = i_sample_value;
            chg_pos_eff = r_start_index;
        end

        fall = i_sample_value < prev_eff;
        rise = i_sample_value > prev_eff;
        take = rise && ({{(32-SAMPLE_BITS){1'b0}}, prev_eff} <
                        {{(32-CEIL_BITS){1'b0}}, r_ceiling})
                    && (!r_best_valid || prev_eff < r_best_val);

        n_prev       = i_sample_value;
        n_cur_pos    = pos;
        n_chg_pos    = (fall || rise) ? pos : chg_pos_eff;
        n_chg_seen   = r_chg_seen || fall || rise;
        n_best_val   = take ? prev_eff : r_best_val;
        n_best_pos   = take ? chg_pos_eff : r_best_pos;
        n_best_valid = r_best_valid || take;
        n_have_prev  = 1'b1;

        if (n_best_valid) begin
            n_out_pos = n_best_pos;
            n_outcome = OUTCOME_VALLEY;
        end else if (n_chg_seen) begin
            n_out_pos = n_chg_pos;
            n_outcome = OUTCOME_CHANGE;
        end else begin
            n_out_pos = '0;
            n_outcome = OUTCOME_NONE;
        end

        // the last sample closes the scan
        if (i_is_last) begin
            n_have_prev  = 1'b0;
            n_chg_seen   = 1'b0;
            n_best_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_index <= '0;
            r_scan_dir    <= 1'b0;
            r_ceiling     <= CEIL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_INDEX:    r_start_index <= i_cfg_data[POS_BITS-1:0];
                CFG_SCAN_DIRECTION: r_scan_dir    <= i_cfg_data[0];
                CFG_VALUE_CEILING:  r_ceiling     <= i_cfg_data[CEIL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= '0;
            r_have_prev  <= 1'b0;
            r_chg_pos    <= '0;
            r_chg_seen   <= 1'b0;
            r_best_val   <= '0;
            r_best_pos   <= '0;
            r_best_valid <= 1'b0;
            r_cur_pos    <= '0;
        end else if (in_accept) begin
            r_prev       <= n_prev;
            r_have_prev  <= n_have_prev;
            r_chg_pos    <= n_chg_pos;
            r_chg_seen   <= n_chg_seen;
            r_best_val   <= n_best_val;
            r_best_pos   <= n_best_pos;
            r_best_valid <= n_best_valid;
            r_cur_pos    <= n_cur_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && i_is_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_is_last) begin
            r_out_pos <= n_out_pos;
            r_outcome <= n_outcome;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_valley_position = r_out_pos;
    assign o_outcome         = r_outcome;

    // a last request always produces a result on the next cycle
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_is_last |=> o_out_valid)
        else $error("last request did not produce a result");

    // a last request closes the scan
    a_last_clears_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_is_last |=> !r_have_prev && !r_best_valid && !r_chg_seen)
        else $error("scan state not cleared after last request");

    // a valley needs a rise, so it implies a seen change
    a_best_needs_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_valid |-> r_chg_seen)
        else $error("valley recorded without a change");

    // the none outcome carries position zero
    a_none_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_outcome == OUTCOME_NONE |-> o_valley_position == '0)
        else $error("none outcome with nonzero position");

endmodule

// ===== tb/valley_check.sv =====
// ----------------------------------------------------------------------------
// valley_check
// Watches the register port and both request channels of the valley finder,
// predicts each scan result from the accepted samples, and compares every
// result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module valley_check (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pvf_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [pvf_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [pvf_pkg::SAMPLE_BITS-1:0]   i_sample_value,
    input  logic                              i_is_last,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [pvf_pkg::POS_BITS-1:0]      i_valley_position,
    input  logic [1:0]                        i_outcome,
    output int                                o_fail_count,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pvf_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [POS_BITS-1:0] pos;
        t_outcome            outcome;
    } t_valley_result;

    t_valley_result expected_valleys[$];

    // register copies
    logic [POS_BITS-1:0]    start_pos;
    logic                   descend;
    logic [CEIL_BITS-1:0]   ceiling;

    // scan state
    logic [SAMPLE_BITS-1:0] prev_sample;
    logic                   have_prev;
    logic [POS_BITS-1:0]    change_pos;
    logic                   change_seen;
    logic [SAMPLE_BITS-1:0] best_value;
    logic [POS_BITS-1:0]    best_pos;
    logic                   best_valid;
    logic [POS_BITS-1:0]    cur_pos;

    int fail_count;
    int result_count;

    task automatic track_sample(input logic [SAMPLE_BITS-1:0] value, input logic last);
        logic [POS_BITS-1:0] pos;
        t_valley_result      res;
        if (have_prev) begin
            // 10-bit arithmetic wraps the same way the scan does
            pos = descend ? cur_pos - 1'b1 : cur_pos + 1'b1;
        end else begin
            pos         = start_pos;
            prev_sample = value;
            change_pos  = pos;
            have_prev   = 1'b1;
        end
        if (value < prev_sample) begin
            change_pos  = pos;
            change_seen = 1'b1;
        end else if (value > prev_sample) begin
            // flat run ending here is a valley candidate
            if (prev_sample < ceiling && (!best_valid || prev_sample < best_value)) begin
                best_value = prev_sample;
                best_pos   = change_pos;
                best_valid = 1'b1;
            end
            change_pos  = pos;
            change_seen = 1'b1;
        end
        prev_sample = value;
        cur_pos     = pos;
        if (last) begin
            if (best_valid) begin
                res.pos     = best_pos;
                res.outcome = OUTCOME_VALLEY;
            end else if (change_seen) begin
                res.pos     = change_pos;
                res.outcome = OUTCOME_CHANGE;
            end else begin
                res.pos     = '0;
                res.outcome = OUTCOME_NONE;
            end
            expected_valleys.push_back(res);
            have_prev   = 1'b0;
            change_seen = 1'b0;
            best_valid  = 1'b0;
        end
    endtask

    task automatic check_result();
        t_valley_result want;
        result_count++;
        if (expected_valleys.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
                $display("result %0d: unexpected, pos %0d outcome %0d",
                         result_count, i_valley_position, i_outcome);
            end
        end else begin
            want = expected_valleys.pop_front();
            if (i_valley_position !== want.pos || i_outcome !== want.outcome) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("result %0d: expected pos %0d outcome %0d, got pos %0d outcome %0d",
                             result_count, want.pos, want.outcome,
                             i_valley_position, i_outcome);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_pos    = '0;
            descend      = 1'b0;
            ceiling      = CEIL_RESET;
            prev_sample  = '0;
            have_prev    = 1'b0;
            change_pos   = '0;
            change_seen  = 1'b0;
            best_value   = '0;
            best_pos     = '0;
            best_valid   = 1'b0;
            cur_pos      = '0;
            fail_count   = 0;
            result_count = 0;
            expected_valleys.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_START_INDEX:    start_pos = i_cfg_data[POS_BITS-1:0];
                    CFG_SCAN_DIRECTION: descend   = i_cfg_data[0];
                    CFG_VALUE_CEILING:  ceiling   = i_cfg_data[CEIL_BITS-1:0];
                    default: ;
                endcase
            end
            // a result leaving now belongs to an earlier sample, so check first
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
            if (i_in_valid && i_in_ready) begin
                track_sample(i_sample_value, i_is_last);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_valleys.size();
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the profile valley finder with directed scans and random scans under
// several register settings, with random gaps on the sample side and random
// stalls on the result side. Checking is done by valley_check.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pvf_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int PHASE_ITEMS  = 50;
    localparam int PHASE_COUNT  = 8;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [SAMPLE_BITS-1:0]   sample_value;
    logic                     is_last;
    logic                     out_valid;
    logic                     out_ready;
    logic [POS_BITS-1:0]      valley_position;
    logic [1:0]               outcome;

    int fail_count;
    int pending;
    int idle_cycles;
    int item_count;
    logic                 quiet;
    logic [CEIL_BITS-1:0] cur_ceiling;

    profile_valley_finder dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_sample_value    (sample_value),
        .i_is_last         (is_last),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_valley_position (valley_position),
        .o_outcome         (outcome)
    );

    valley_check checker_inst (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_sample_value    (sample_value),
        .i_is_last         (is_last),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_valley_position (valley_position),
        .i_outcome         (outcome),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    // watchdog: cycles in which nothing moves on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // result side: random stall before each result, sometimes none
    initial begin
        int stall;
        out_ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    task automatic set_scan_regs(input logic [POS_BITS-1:0] start, input logic descend,
                                 input logic [CEIL_BITS-1:0] ceiling);
        drain();
        write_reg(CFG_START_INDEX, CFG_DATA_BITS'(start));
        write_reg(CFG_SCAN_DIRECTION, CFG_DATA_BITS'(descend));
        write_reg(CFG_VALUE_CEILING, ceiling);
        @(posedge i_clk);
        cfg_we      <= 1'b0;
        cur_ceiling = ceiling;
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input logic last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid     <= 1'b1;
        sample_value <= value;
        is_last      <= last;
        do @(posedge i_clk); while (!in_ready);
        item_count++;
    endtask

    task automatic send_scan(input logic [SAMPLE_BITS-1:0] values[$]);
        foreach (values[k]) begin
            send_sample(values[k], k == values.size() - 1);
        end
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int mode,
                                                           input logic [SAMPLE_BITS-1:0] prev);
        int near;
        // flats are what make a valley, so repeat often
        if ($urandom_range(0, 2) == 0) begin
            return prev;
        end
        case (mode)
            0: return SAMPLE_BITS'($urandom_range(0, 15));
            1: return SAMPLE_BITS'($urandom);
            default: begin
                near = int'(cur_ceiling) + $urandom_range(0, 16) - 8;
                if (near < 0) near = 0;
                if (near > 65535) near = 65535;
                return SAMPLE_BITS'(near);
            end
        endcase
    endfunction

    task automatic random_scan();
        int len;
        int mode;
        logic [SAMPLE_BITS-1:0] v;
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        mode  = $urandom_range(0, 2);
        quiet = ($urandom_range(0, 3) == 0);
        v     = pick_sample(mode, '0);
        for (int k = 0; k < len; k++) begin
            v = pick_sample(mode, v);
            send_sample(v, k == len - 1);
        end
    endtask

    initial begin
        int phase_start;
        logic [CEIL_BITS-1:0] ceil_pick;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_START_INDEX;
        cfg_data     = '0;
        in_valid     = 1'b0;
        sample_value = '0;
        is_last      = 1'b0;
        quiet        = 1'b0;
        cur_ceiling  = CEIL_RESET;
        item_count   = 0;
        idle_cycles  = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: single sample gives no change at all
        send_scan('{16'd42});
        // fall, flat bottom, rise: valley at the fall
        send_scan('{16'd500, 16'd300, 16'd300, 16'd800});
        // rise on the second sample: first run valley sits at the start index
        send_scan('{16'd0, 16'd65535});
        // only a fall: fallback change point
        send_scan('{16'd9, 16'd4});

        // wrap past the top, ceiling blocks every valley
        set_scan_regs(10'd1023, 1'b0, 16'd0);
        send_scan('{16'd5, 16'd3, 16'd7});
        // flat scan, nothing seen
        send_scan('{16'd7, 16'd7, 16'd7});

        // descending wrap below zero, widest ceiling
        set_scan_regs(10'd0, 1'b1, 16'd65535);
        send_scan('{16'd65535, 16'd0, 16'd0, 16'd65535, 16'd65535});
        send_scan('{16'd65534, 16'd65535});

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: set_scan_regs(10'd0, 1'b0, 16'd65535);
                1: set_scan_regs(10'd1023, 1'b1, 16'd0);
                default: begin
                    ceil_pick = ($urandom_range(0, 1) == 0) ? CEIL_BITS'($urandom_range(0, 20))
                                                            : CEIL_BITS'($urandom);
                    set_scan_regs(POS_BITS'($urandom), 1'($urandom), ceil_pick);
                end
            endcase
            phase_start = item_count;
            while (item_count - phase_start < PHASE_ITEMS) begin
                random_scan();
            end
        end

        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== profile_valley_finder.f =====
hw/rtl/pvf_pkg.sv
hw/rtl/profile_valley_finder.sv
tb/valley_check.sv
tb/testbench.sv
